FILE: sv/prrs_pkg.sv
// Types and constants shared by the round-robin scheduler core and its ready-table cells.
// No dependencies.
package prrs_pkg;

  localparam int unsigned TASK_W    = 3;
  localparam int unsigned PRIO_W    = 5;
  localparam int unsigned SLICE_W   = 16;
  localparam int unsigned DLY_IN_W  = 16;
  localparam int unsigned LOCK_W    = 8;
  localparam logic [LOCK_W-1:0]  LOCK_MAX    = 8'd255;
  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

  typedef enum logic [2:0] {
    CMD_READY    = 3'd0,
    CMD_UNREADY  = 3'd1,
    CMD_DELAY    = 3'd2,
    CMD_CANCEL   = 3'd3,
    CMD_TICK     = 3'd4,
    CMD_LOCK     = 3'd5,
    CMD_UNLOCK   = 3'd6,
    CMD_SCHEDULE = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REM,
    ST_APP,
    ST_WAKE,
    ST_WADV,
    ST_SLICE,
    ST_HEAD,
    ST_SCHED,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [TASK_W-1:0]   task_id;
    logic [PRIO_W-1:0]   priority_req;
    logic [DLY_IN_W-1:0] delay_ticks;
  } item_t;

  typedef struct packed {
    logic              switch_now;
    logic [TASK_W-1:0] next_task;
    logic              ready_empty;
    logic [LOCK_W-1:0] lock_level;
  } result_t;

  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
    logic              valid;
  } entry_t;

  typedef struct packed {
    logic              rem;
    logic              app;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
  } cell_ctl_t;

endpackage

FILE: sv/prrs_cell.sv
// One entry of the ready table; shifts left on remove, fills the first free slot on append.
// Depends on prrs_pkg.
module prrs_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prrs_pkg::cell_ctl_t ctl_i,
  input  prrs_pkg::entry_t   right_i,
  input  logic               left_valid_i,
  input  logic               hit_i,
  output logic               hit_o,
  output prrs_pkg::entry_t   ent_o
);
  import prrs_pkg::*;

  entry_t ent_q, ent_d;

  assign hit_o = hit_i | (ent_q.valid && (ent_q.task_id == ctl_i.task_id));
  assign ent_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.rem && hit_o) begin
      ent_d = right_i;
    end else if (ctl_i.app && !ent_q.valid && left_valid_i) begin
      ent_d.task_id = ctl_i.task_id;
      ent_d.prio    = ctl_i.prio;
      ent_d.valid   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_q.valid |-> left_valid_i) else $error("ready table has a hole");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.app && !ctl_i.rem && !ent_q.valid && left_valid_i) |=> ent_q.valid)
    else $error("append missed free slot");
  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.rem && hit_o) |=> (ent_q == $past(right_i)))
    else $error("remove did not shift");

endmodule

FILE: sv/priority_round_robin_scheduler_core.sv
// Top level of the priority round-robin scheduler: command sequencer, per-task timers, ready table.
// Depends on prrs_pkg and prrs_cell.
//
// One command is taken when start is high and busy is low; its result appears on result_o for
// one cycle with done_o high and cannot be held off. The sequencer works on one command at a
// time and walks the ready-table cells one per cycle: lock, delay and cancel end in the execute
// state; ready removes and appends the task, unready removes it; schedule and the final unlock scan
// the table; tick steps each task timer, appends woken tasks, rotates on slice expiry, then scans.
module priority_round_robin_scheduler_core #(
  parameter int unsigned NUM_TASKS  = 8,
  parameter int unsigned NUM_PRIOS  = 32,
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  prrs_pkg::item_t                item_i,
  output logic                           done_o,
  output prrs_pkg::result_t              result_o,
  input  logic                           cfg_we_i,
  input  logic [prrs_pkg::SLICE_W-1:0]   cfg_wdata_i
);
  import prrs_pkg::*;

  localparam int unsigned IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  state_e              state_q, state_d, ret_q, ret_d;
  item_t               item_q;
  logic [IW-1:0]       idx_q, idx_d;
  logic                app_q, app_d;
  logic [TASK_W-1:0]   op_task_q, op_task_d;
  logic [PRIO_W-1:0]   op_prio_q, op_prio_d;
  logic [PRIO_W-1:0]   tgt_q, tgt_d;
  logic                found_q, found_d;
  logic [PRIO_W-1:0]   bprio_q, bprio_d;
  logic [TASK_W-1:0]   btask_q, btask_d;
  logic                sw_q, sw_d;
  logic [TASK_W-1:0]   run_q, run_d;
  logic                run_valid_q, run_valid_d;
  logic [LOCK_W-1:0]   lock_q, lock_d;
  logic [SLICE_W-1:0]  slice_len_q;

  logic [PRIO_W-1:0]     tprio_q [NUM_TASKS];
  logic [PRIO_W-1:0]     tprio_d [NUM_TASKS];
  logic [DELAY_BITS-1:0] dleft_q [NUM_TASKS];
  logic [DELAY_BITS-1:0] dleft_d [NUM_TASKS];
  logic                  dact_q  [NUM_TASKS];
  logic                  dact_d  [NUM_TASKS];
  logic [SLICE_W-1:0]    slice_q [NUM_TASKS];
  logic [SLICE_W-1:0]    slice_d [NUM_TASKS];

  entry_t    cells_w [NUM_TASKS];
  logic      hits_w  [NUM_TASKS];
  cell_ctl_t ctl;

  entry_t                e;
  logic                  last;
  logic                  tid_ok;
  logic [IW-1:0]         tid_idx;
  logic [IW-1:0]         rt_idx;
  logic [PRIO_W-1:0]     prq;
  logic [DELAY_BITS-1:0] dnew;
  logic [SLICE_W-1:0]    snew;
  logic                  cand;
  logic                  bf;
  logic [TASK_W-1:0]     bt;

  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
    entry_t right_w;
    logic   lv_w;
    logic   hin_w;
    if (g == NUM_TASKS - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_mid
      assign right_w = cells_w[g+1];
    end
    if (g == 0) begin : g_first
      assign lv_w  = 1'b1;
      assign hin_w = 1'b0;
    end else begin : g_rest
      assign lv_w  = cells_w[g-1].valid;
      assign hin_w = hits_w[g-1];
    end
    prrs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .right_i      (right_w),
      .left_valid_i (lv_w),
      .hit_i        (hin_w),
      .hit_o        (hits_w[g]),
      .ent_o        (cells_w[g])
    );
  end

  assign e       = cells_w[idx_q];
  assign last    = (idx_q == IW'(NUM_TASKS - 1));
  assign tid_ok  = (int'(item_q.task_id) < NUM_TASKS);
  assign tid_idx = IW'(item_q.task_id);
  assign rt_idx  = IW'(run_q);
  assign prq     = (int'(item_q.priority_req) > NUM_PRIOS - 1) ?
                   PRIO_W'(NUM_PRIOS - 1) : item_q.priority_req;
  assign dnew    = dleft_q[idx_q] - 1'b1;
  assign snew    = slice_q[idx_q] - 1'b1;
  assign cand    = e.valid && (!found_q || (e.prio < bprio_q));
  assign bf      = found_q || e.valid;
  assign bt      = cand ? e.task_id : btask_q;

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = (state_q == ST_DONE);
  assign result_o.switch_now  = sw_q;
  assign result_o.next_task   = run_q;
  assign result_o.ready_empty = !cells_w[0].valid;
  assign result_o.lock_level  = lock_q;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    idx_d       = idx_q;
    app_d       = app_q;
    op_task_d   = op_task_q;
    op_prio_d   = op_prio_q;
    tgt_d       = tgt_q;
    found_d     = found_q;
    bprio_d     = bprio_q;
    btask_d     = btask_q;
    sw_d        = sw_q;
    run_d       = run_q;
    run_valid_d = run_valid_q;
    lock_d      = lock_q;
    tprio_d     = tprio_q;
    dleft_d     = dleft_q;
    dact_d      = dact_q;
    slice_d     = slice_q;
    ctl         = '{rem: 1'b0, app: 1'b0, task_id: op_task_q, prio: op_prio_q};
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          sw_d    = 1'b0;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (item_q.cmd)
          CMD_READY: begin
            if (tid_ok) begin
              tprio_d[tid_idx] = prq;
              op_task_d = item_q.task_id;
              op_prio_d = prq;
              app_d     = 1'b1;
              ret_d     = ST_DONE;
              state_d   = ST_REM;
            end
          end
          CMD_UNREADY: begin
            if (tid_ok) begin
              op_task_d = item_q.task_id;
              app_d     = 1'b0;
              ret_d     = ST_DONE;
              state_d   = ST_REM;
            end
          end
          CMD_DELAY: begin
            if (tid_ok) begin
              dleft_d[tid_idx] = DELAY_BITS'(item_q.delay_ticks);
              dact_d[tid_idx]  = 1'b1;
            end
          end
          CMD_CANCEL: begin
            if (tid_ok) begin
              dact_d[tid_idx] = 1'b0;
            end
          end
          CMD_TICK: begin
            idx_d   = '0;
            state_d = ST_WAKE;
          end
          CMD_LOCK: begin
            if (lock_q != LOCK_MAX) begin
              lock_d = lock_q + 1'b1;
            end
          end
          CMD_UNLOCK: begin
            if (lock_q != '0) begin
              lock_d = lock_q - 1'b1;
              if (lock_q == LOCK_W'(1)) begin
                idx_d   = '0;
                found_d = 1'b0;
                state_d = ST_SCHED;
              end
            end
          end
          CMD_SCHEDULE: begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = ST_SCHED;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_REM: begin
        ctl.rem = 1'b1;
        if (app_q) begin
          state_d = ST_APP;
        end else begin
          state_d = ret_q;
        end
      end
      ST_APP: begin
        ctl.app = 1'b1;
        state_d = ret_q;
        if (ret_q == ST_SCHED) begin
          idx_d   = '0;
          found_d = 1'b0;
        end
      end
      ST_WAKE: begin
        state_d = ST_WADV;
        if (dact_q[idx_q]) begin
          dleft_d[idx_q] = dnew;
          if (dnew == '0) begin
            dact_d[idx_q] = 1'b0;
            op_task_d = TASK_W'(idx_q);
            op_prio_d = tprio_q[idx_q];
            app_d     = 1'b1;
            ret_d     = ST_WADV;
            state_d   = ST_REM;
          end
        end
      end
      ST_WADV: begin
        if (last) begin
          idx_d   = rt_idx;
          state_d = ST_SLICE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_WAKE;
        end
      end
      ST_SLICE: begin
        idx_d   = '0;
        found_d = 1'b0;
        state_d = ST_SCHED;
        if (run_valid_q) begin
          slice_d[idx_q] = snew;
          if (snew == '0) begin
            tgt_d   = tprio_q[idx_q];
            state_d = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        if (e.valid && (e.prio == tgt_q)) begin
          op_task_d       = e.task_id;
          op_prio_d       = e.prio;
          app_d           = 1'b1;
          ret_d           = ST_SCHED;
          slice_d[rt_idx] = slice_len_q;
          state_d         = ST_REM;
        end else if (last) begin
          idx_d   = '0;
          found_d = 1'b0;
          state_d = ST_SCHED;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SCHED: begin
        if (cand) begin
          bprio_d = e.prio;
          btask_d = e.task_id;
        end
        found_d = bf;
        if (last) begin
          state_d = ST_DONE;
          if ((lock_q == '0) && bf && !(run_valid_q && (bt == run_q))) begin
            run_d       = bt;
            run_valid_d = 1'b1;
            sw_d        = 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_DONE;
      idx_q       <= '0;
      app_q       <= 1'b0;
      found_q     <= 1'b0;
      sw_q        <= 1'b0;
      run_q       <= '0;
      run_valid_q <= 1'b0;
      lock_q      <= '0;
      slice_len_q <= SLICE_RESET;
      for (int i = 0; i < NUM_TASKS; i++) begin
        tprio_q[i] <= '0;
        dleft_q[i] <= '0;
        dact_q[i]  <= 1'b0;
        slice_q[i] <= SLICE_RESET;
      end
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      idx_q       <= idx_d;
      app_q       <= app_d;
      found_q     <= found_d;
      sw_q        <= sw_d;
      run_q       <= run_d;
      run_valid_q <= run_valid_d;
      lock_q      <= lock_d;
      tprio_q     <= tprio_d;
      dleft_q     <= dleft_d;
      dact_q      <= dact_d;
      slice_q     <= slice_d;
      if (cfg_we_i) begin
        slice_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= item_i;
    end
    op_task_q <= op_task_d;
    op_prio_q <= op_prio_d;
    tgt_q     <= tgt_d;
    bprio_q   <= bprio_d;
    btask_q   <= btask_d;
  end

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("transaction not taken");
  a_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.switch_now) |-> (run_valid_q && !result_o.ready_empty))
    else $error("switch without ready task");

endmodule
